[design/matrix_multiply_engine_assert.svh]
// assertion macros shared by the matrix multiply engine modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mme_pkg.sv]
// types, codes and helpers for the matrix multiply engine
// no dependencies
package mme_pkg;

    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIM_ERR = 1'b1;

    localparam int          FRAC_BITS = 16;
    localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_mme_state;

    typedef struct packed {
        logic [1:0]          func;
        logic [2:0]          row;
        logic [2:0]          col;
        logic signed [31:0]  value;
    } t_mme_item;

    typedef struct packed {
        logic [2:0]          out_row;
        logic [2:0]          out_col;
        logic signed [31:0]  out_value;
        logic                status;
        logic                last;
    } t_mme_result;

    typedef struct packed {
        logic [3:0] a_rows;
        logic [3:0] a_cols;
        logic [3:0] b_rows;
        logic [3:0] b_cols;
    } t_mme_dims;

    // travels alongside the operands read from the stores
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       elem_last;
        logic       final_elem;
        logic       err;
        logic [2:0] row;
        logic [2:0] col;
    } t_mme_tag;

    // loop count from a dimension register: 0 counts as 1, clamp at lim
    function automatic logic [4:0] eff_dim(input logic [3:0] d, input logic [4:0] lim);
        logic [4:0] v;
        v = {1'b0, d};
        if (v == 5'd0) begin
            return 5'd1;
        end
        if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

endpackage

[design/mme_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/mme_seq.sv]
// loop sequencer: walks i, j, k over the product and issues store reads
// depends on mme_pkg and matrix_multiply_engine_assert.svh
`include "matrix_multiply_engine_assert.svh"

module mme_seq
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW     = $clog2(MAX_DIM + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_compute,
    input  t_mme_dims     i_dims,
    input  logic          i_done,
    output logic          o_busy,
    output logic [AW-1:0] o_a_raddr,
    output logic [AW-1:0] o_b_raddr,
    output t_mme_tag      o_tag
);

    t_mme_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CW-1:0] r_ni, n_ni, r_nj, n_nj, r_nk, n_nk;
    t_mme_tag r_tag, n_tag;
    logic mismatch, k_end, j_end, i_end;

    assign mismatch = (i_dims.a_cols != i_dims.b_rows);
    assign k_end = (r_k == r_nk - CW'(1));
    assign j_end = (r_j == r_nj - CW'(1));
    assign i_end = (r_i == r_ni - CW'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_compute) begin
                    n_state = mismatch ? S_DRAIN : S_RUN;
                end
            end
            S_RUN: begin
                if (k_end && j_end && i_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_i   = r_i;
        n_j   = r_j;
        n_k   = r_k;
        n_ni  = r_ni;
        n_nj  = r_nj;
        n_nk  = r_nk;
        n_tag = '0;
        case (r_state)
            S_IDLE: begin
                n_i  = '0;
                n_j  = '0;
                n_k  = '0;
                n_ni = CW'(eff_dim(i_dims.a_rows, 5'(MAX_DIM)));
                n_nj = CW'(eff_dim(i_dims.b_cols, 5'(MAX_DIM)));
                n_nk = CW'(eff_dim(i_dims.a_cols, 5'(MAX_DIM)));
                // dimension error goes down the pipe as a single flagged item
                if (i_compute && mismatch) begin
                    n_tag.valid      = 1'b1;
                    n_tag.first      = 1'b1;
                    n_tag.elem_last  = 1'b1;
                    n_tag.final_elem = 1'b1;
                    n_tag.err        = 1'b1;
                end
            end
            S_RUN: begin
                n_tag.valid      = 1'b1;
                n_tag.first      = (r_k == '0);
                n_tag.elem_last  = k_end;
                n_tag.final_elem = k_end && j_end && i_end;
                n_tag.row        = 3'(r_i);
                n_tag.col        = 3'(r_j);
                if (k_end) begin
                    n_k = '0;
                    if (j_end) begin
                        n_j = '0;
                        n_i = r_i + CW'(1);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DRAIN: begin
                n_tag = '0;
            end
            default: n_tag = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tag   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ni    <= CW'(1);
            r_nj    <= CW'(1);
            r_nk    <= CW'(1);
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_ni    <= n_ni;
            r_nj    <= n_nj;
            r_nk    <= n_nk;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_a_raddr = AW'(r_i) * AW'(MAX_DIM) + AW'(r_k);
    assign o_b_raddr = AW'(r_k) * AW'(MAX_DIM) + AW'(r_j);
    assign o_tag     = r_tag;

    `MME_ASSERT_SAME(a_final_in_drain, r_tag.valid && r_tag.final_elem, r_state == S_DRAIN,
        "final element issued while sequencer not draining")
    `MME_ASSERT_SAME(a_run_in_range, r_state == S_RUN,
        (r_i < r_ni) && (r_j < r_nj) && (r_k < r_nk), "loop counter beyond its bound")
    `MME_ASSERT_NEXT(a_idle_quiet, r_state == S_IDLE && !i_compute, !r_tag.valid,
        "read issued without a compute transfer")

endmodule

[design/mme_mac.sv]
// shared multiply-accumulate unit with q16.16 scaling and saturation
// depends on mme_pkg and matrix_multiply_engine_assert.svh
`include "matrix_multiply_engine_assert.svh"

module mme_mac
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8,
    localparam int ACC_W  = 64 + $clog2(MAX_DIM) + 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mme_tag    i_tag,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_strobe,
    output t_mme_result o_result
);

    logic signed [63:0]    r_prod;
    t_mme_tag              r_ptag;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    t_mme_tag              r_atag;
    logic                  r_out_valid;
    t_mme_result           r_out, n_out;
    logic                  fits;

    always_comb begin
        n_acc = r_acc;
        if (r_ptag.valid) begin
            if (r_ptag.first) begin
                n_acc = ACC_W'(r_prod);
            end else begin
                n_acc = r_acc + ACC_W'(r_prod);
            end
        end
    end

    // result fits when bit 47 and everything above it are pure sign
    assign fits = (&r_acc[ACC_W-1:FRAC_BITS+31]) | ~(|r_acc[ACC_W-1:FRAC_BITS+31]);

    always_comb begin
        n_out.out_row = r_atag.row;
        n_out.out_col = r_atag.col;
        n_out.last    = r_atag.final_elem;
        if (r_atag.err) begin
            n_out.out_value = '0;
            n_out.status    = STATUS_DIM_ERR;
            n_out.out_row   = '0;
            n_out.out_col   = '0;
        end else begin
            n_out.status = STATUS_OK;
            if (fits) begin
                n_out.out_value = r_acc[FRAC_BITS+31:FRAC_BITS];
            end else begin
                n_out.out_value = r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag      <= '0;
            r_atag      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptag      <= i_tag;
            r_atag      <= r_ptag;
            r_out_valid <= r_atag.valid && r_atag.elem_last;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    `MME_ASSERT_SAME(a_err_is_last, o_strobe && o_result.status == STATUS_DIM_ERR,
        o_result.last, "dimension error result not marked last")
    `MME_ASSERT_SAME(a_strobe_from_elem, o_strobe,
        $past(r_atag.valid && r_atag.elem_last), "result without a finished dot product")
    `MME_ASSERT_NEXT(a_sum_to_result, r_atag.valid && r_atag.elem_last, o_strobe,
        "finished dot product dropped")

endmodule

[design/matrix_multiply_engine.sv]
// Matrix multiply engine, signed Q16.16. A load transfer (func load A / load B)
// writes one element; busy stays low. A compute transfer holds busy high
// while it walks the ni*nj*nk products, where ni = a_rows, nj = b_cols and
// nk = a_cols after clamping to 1..MAX_DIM: one multiply-accumulate per cycle
// through a single shared 32x32 multiplier, fed by one read port on each
// element store, followed by the read, multiply, accumulate and output
// registers. A dimension mismatch skips the loop and gives one result.
// Results appear on o_result for one cycle with o_strobe and cannot be stalled;
// consecutive elements may come on consecutive cycles when nk is 1. busy drops
// in the cycle after the final strobe. Write the dimension registers only while
// busy is low.
// depends on mme_pkg, mme_ram, mme_seq, mme_mac
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_mme_item   i_item,
    output logic        o_strobe,
    output t_mme_result o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    t_mme_dims     r_dims;
    logic          accept, in_range, we_a, we_b, compute;
    logic [AW-1:0] waddr, a_raddr, b_raddr;
    logic [31:0]   a_rdata, b_rdata;
    t_mme_tag      tag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.a_rows <= 4'd1;
            r_dims.a_cols <= 4'd1;
            r_dims.b_rows <= 4'd1;
            r_dims.b_cols <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_A_ROWS: r_dims.a_rows <= i_cfg_data;
                CFG_A_COLS: r_dims.a_cols <= i_cfg_data;
                CFG_B_ROWS: r_dims.b_rows <= i_cfg_data;
                CFG_B_COLS: r_dims.b_cols <= i_cfg_data;
                default: r_dims <= r_dims;
            endcase
        end
    end

    assign accept   = start && !busy;
    assign in_range = ({2'b00, i_item.row} < 5'(MAX_DIM)) && ({2'b00, i_item.col} < 5'(MAX_DIM));
    assign waddr    = AW'(i_item.row) * AW'(MAX_DIM) + AW'(i_item.col);
    assign we_a     = accept && in_range && (i_item.func == FUNC_LOAD_A);
    assign we_b     = accept && in_range && (i_item.func == FUNC_LOAD_B);
    assign compute  = accept && (i_item.func == FUNC_COMPUTE);

    mme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_item.value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_item.value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_compute (compute),
        .i_dims    (r_dims),
        .i_done    (o_strobe && o_result.last),
        .o_busy    (busy),
        .o_a_raddr (a_raddr),
        .o_b_raddr (b_raddr),
        .o_tag     (tag)
    );

    mme_mac #(.MAX_DIM(MAX_DIM)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_a      (a_rdata),
        .i_b      (b_rdata),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
